FILE: hdl/tctlm_pkg.sv
// shared types and constants for the text code table longest match unit
package tctlm_pkg;

  localparam int MaxEntries   = 256;
  localparam int MaxCodeBytes = 4;
  localparam int MaxTextBytes = 8;

  localparam int CodeW    = 32;
  localparam int CodeLenW = 3;
  localparam int TextW    = 64;
  localparam int TextLenW = 4;
  localparam int IndexW   = 8;

  typedef enum logic [2:0] {
    CMD_CLEAR    = 3'd0,
    CMD_ADD      = 3'd1,
    CMD_SET_TERM = 3'd2,
    CMD_MATCH_TX = 3'd3,
    CMD_MATCH_CD = 3'd4,
    CMD_EMIT     = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_HIT  = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_FETCH_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [IndexW-1:0]   entry_index;
    logic [CodeW-1:0]    code_out;
    logic [CodeLenW-1:0] code_len_out;
    logic [TextW-1:0]    text_out;
    logic [TextLenW-1:0] text_len_out;
  } result_t;

  // byte mask of n low bytes over a 64-bit word
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < int'(n)) m[b*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

FILE: hdl/text_code_table_longest_match_unit.sv
// top level of the text code table longest match unit
//
//  channel | dir | fields (low bit up)
//  s_axis  | in  | tdata: cmd, code_bytes, code_len, text_bytes, text_len
//  m_axis  | out | tdata: status, entry_index, code_out, code_len_out,
//          |     |        text_out, text_len_out
//
// clear, add, set terminator and emit are taken, then answered from the result register
// a match reads every stored entry once through the single memory read port;
// on a hit the winner is reread (fetch, fetch wait) so its whole entry lands in the result
// reset (rst, synchronous) empties the table and sets the terminator to byte 00
// the result register holds until taken; a new item is taken once it is free
module text_code_table_longest_match_unit #(
  parameter int MaxEntries   = tctlm_pkg::MaxEntries,
  parameter int MaxCodeBytes = tctlm_pkg::MaxCodeBytes,
  parameter int MaxTextBytes = tctlm_pkg::MaxTextBytes
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd[2:0], code_bytes[34:3], code_len[37:35], text_bytes[101:38],
  // text_len[105:102], zero fill to 112
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], entry_index[9:2], code_out[41:10], code_len_out[44:42],
  // text_out[108:45], text_len_out[112:109], zero fill to 120
  output logic [119:0] m_axis_tdata
);
  localparam int AW   = $clog2(MaxEntries);
  localparam int CntW = AW + 1;
  // packed entry word: text_len, text, code_len, code
  localparam int EW = tctlm_pkg::TextLenW + tctlm_pkg::TextW
                    + tctlm_pkg::CodeLenW + tctlm_pkg::CodeW;

  tctlm_pkg::state_t state, state_next;

  // input field unpack with length saturation
  logic [2:0]  in_cmd;
  logic [2:0]  in_clen_raw, in_clen;
  logic [3:0]  in_tlen_raw, in_tlen;
  logic [31:0] in_code;
  logic [63:0] in_text;
  logic [63:0] code_mask;

  assign in_cmd      = s_axis_tdata[2:0];
  assign in_clen_raw = s_axis_tdata[37:35];
  assign in_tlen_raw = s_axis_tdata[105:102];
  assign in_clen = (in_clen_raw > 3'(MaxCodeBytes)) ? 3'(MaxCodeBytes) : in_clen_raw;
  assign in_tlen = (in_tlen_raw > 4'(MaxTextBytes)) ? 4'(MaxTextBytes) : in_tlen_raw;
  assign code_mask = tctlm_pkg::byte_mask({1'b0, in_clen});
  assign in_code = s_axis_tdata[34:3] & code_mask[31:0];
  assign in_text = s_axis_tdata[101:38] & tctlm_pkg::byte_mask(in_tlen);

  // control registers
  logic [CntW-1:0] entry_total;
  logic [31:0]     end_code;
  logic [2:0]      end_code_length;

  // item in flight
  logic            by_text;
  logic [63:0]     window;
  logic [3:0]      wlen;
  logic [CntW-1:0] scan_addr;   // next address issued
  logic            rd_valid;    // read data this cycle belongs to a scan
  logic [AW-1:0]   rd_idx;
  logic            best_hit;
  logic [AW-1:0]   best_idx;
  logic [3:0]      best_len;
  tctlm_pkg::result_t res;

  // memory
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [EW-1:0]   ram_wdata, ram_rdata;

  tctlm_entry_ram #(.Depth(MaxEntries), .Width(EW)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [31:0] rd_code;
  logic [2:0]  rd_clen;
  logic [63:0] rd_text;
  logic [3:0]  rd_tlen;
  assign {rd_tlen, rd_text, rd_clen, rd_code} = ram_rdata;

  // candidate compare on the word just read
  logic [63:0] cand_s;
  logic [3:0]  cand_l;
  logic        cand_ok;
  assign cand_s  = by_text ? rd_text : {32'd0, rd_code};
  assign cand_l  = by_text ? rd_tlen : {1'b0, rd_clen};
  assign cand_ok = rd_valid && (cand_l > best_len) && (cand_l <= wlen)
                && (((cand_s ^ window) & tctlm_pkg::byte_mask(cand_l)) == 64'd0);

  logic accept_in, take_out, full;
  assign s_axis_tready = (state == tctlm_pkg::S_IDLE);
  assign accept_in = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state == tctlm_pkg::S_OUT);
  assign take_out = m_axis_tvalid && m_axis_tready;
  assign full = (entry_total >= CntW'(MaxEntries));

  assign ram_we    = accept_in && (in_cmd == tctlm_pkg::CMD_ADD) && !full;
  assign ram_waddr = entry_total[AW-1:0];
  assign ram_wdata = {in_tlen, in_text, in_clen, in_code};
  assign ram_raddr = (state == tctlm_pkg::S_FETCH) ? best_idx : scan_addr[AW-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tctlm_pkg::S_IDLE: begin
        if (accept_in) begin
          if (in_cmd == tctlm_pkg::CMD_MATCH_TX || in_cmd == tctlm_pkg::CMD_MATCH_CD)
            state_next = tctlm_pkg::S_SCAN;
          else
            state_next = tctlm_pkg::S_OUT;
        end
      end
      tctlm_pkg::S_SCAN: begin
        if (scan_addr >= entry_total && !rd_valid) begin
          state_next = (best_hit || cand_ok) ? tctlm_pkg::S_FETCH : tctlm_pkg::S_OUT;
        end
      end
      tctlm_pkg::S_FETCH:      state_next = tctlm_pkg::S_FETCH_WAIT;
      tctlm_pkg::S_FETCH_WAIT: state_next = tctlm_pkg::S_OUT;
      tctlm_pkg::S_OUT:        if (take_out) state_next = tctlm_pkg::S_IDLE;
      default:                 state_next = tctlm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tctlm_pkg::S_IDLE;
    else     state <= state_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_total     <= '0;
      end_code        <= '0;
      end_code_length <= 3'd1;
      rd_valid        <= 1'b0;
      best_hit        <= 1'b0;
    end else begin
      if (accept_in) begin
        unique case (in_cmd)
          tctlm_pkg::CMD_CLEAR: begin
            entry_total     <= '0;
            end_code        <= '0;
            end_code_length <= 3'd1;
          end
          tctlm_pkg::CMD_ADD:      if (!full) entry_total <= entry_total + 1'b1;
          tctlm_pkg::CMD_SET_TERM: begin
            end_code        <= in_code;
            end_code_length <= in_clen;
          end
          default: ;
        endcase
        best_hit <= 1'b0;
        rd_valid <= 1'b0;
      end else if (state == tctlm_pkg::S_SCAN) begin
        rd_valid <= (scan_addr < entry_total);
        if (cand_ok) best_hit <= 1'b1;
      end else begin
        rd_valid <= 1'b0;
      end
    end
  end

  // scan datapath and result register
  always_ff @(posedge clk) begin
    if (accept_in) begin
      by_text   <= (in_cmd == tctlm_pkg::CMD_MATCH_TX);
      window    <= (in_cmd == tctlm_pkg::CMD_MATCH_TX) ? in_text : {32'd0, in_code};
      wlen      <= (in_cmd == tctlm_pkg::CMD_MATCH_TX) ? in_tlen : {1'b0, in_clen};
      scan_addr <= '0;
      best_len  <= '0;
      best_idx  <= '0;
      res       <= '0;
      unique case (in_cmd)
        tctlm_pkg::CMD_ADD: begin
          if (full) begin
            res.status <= tctlm_pkg::ST_FULL;
          end else begin
            res.entry_index  <= 8'(entry_total[AW-1:0]);
            res.code_out     <= in_code;
            res.code_len_out <= in_clen;
            res.text_out     <= in_text;
            res.text_len_out <= in_tlen;
          end
        end
        tctlm_pkg::CMD_SET_TERM: begin
          res.code_out     <= in_code;
          res.code_len_out <= in_clen;
        end
        tctlm_pkg::CMD_EMIT: begin
          res.code_out     <= end_code;
          res.code_len_out <= end_code_length;
        end
        tctlm_pkg::CMD_MATCH_TX, tctlm_pkg::CMD_MATCH_CD: res.status <= tctlm_pkg::ST_NO_HIT;
        default: ;
      endcase
    end else if (state == tctlm_pkg::S_SCAN) begin
      if (scan_addr < entry_total) scan_addr <= scan_addr + 1'b1;
      rd_idx <= scan_addr[AW-1:0];
      if (cand_ok) begin
        best_len <= cand_l;
        best_idx <= rd_idx;
      end
    end else if (state == tctlm_pkg::S_FETCH_WAIT) begin
      // reread winner so its whole entry lands in the result
      res.status       <= tctlm_pkg::ST_OK;
      res.entry_index  <= 8'(best_idx);
      res.code_out     <= rd_code;
      res.code_len_out <= rd_clen;
      res.text_out     <= rd_text;
      res.text_len_out <= rd_tlen;
    end
  end

  assign m_axis_tdata = {7'd0, res.text_len_out, res.text_out, res.code_len_out,
                         res.code_out, res.entry_index, res.status};

endmodule

FILE: hdl/tctlm_entry_ram.sv
// entry store: one synchronous memory, one write port, one registered read port
module tctlm_entry_ram #(
  parameter int Depth = tctlm_pkg::MaxEntries,
  parameter int Width = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/tctlm_checker.sv
// port-level checker for the text code table longest match unit
module tctlm_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [111:0] s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [119:0] m_axis_tdata
);
  // one item in flight: no input taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");

  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // status code never beyond store full
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] <= tctlm_pkg::ST_FULL) else $error("bad status");

  // a non-match command answers on the next cycle
  a_quick: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[2:0] != tctlm_pkg::CMD_MATCH_TX
      && s_axis_tdata[2:0] != tctlm_pkg::CMD_MATCH_CD |=> m_axis_tvalid)
    else $error("late result");
endmodule

bind text_code_table_longest_match_unit tctlm_checker u_tctlm_checker (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tdata(s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

FILE: tb/tb_table_checker.sv
// checker for the text code table: predicts each result and compares on the output channel
`timescale 1ns / 1ps
module tb_table_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [119:0] m_axis_tdata,
  output int           fail_count,
  output int           pending_count
);
  logic [tctlm_pkg::CodeW-1:0] code_tab [tctlm_pkg::MaxEntries];
  logic [2:0]                  clen_tab [tctlm_pkg::MaxEntries];
  logic [tctlm_pkg::TextW-1:0] text_tab [tctlm_pkg::MaxEntries];
  logic [3:0]                  tlen_tab [tctlm_pkg::MaxEntries];
  int                          entries;
  logic [tctlm_pkg::CodeW-1:0] term_code;
  logic [2:0]                  term_len;
  logic [119:0]                want_q [$];

  function automatic logic [63:0] low_bytes(input int n);
    return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  function automatic logic [119:0] pack_result(input logic [1:0] st, input logic [7:0] idx,
      input logic [31:0] cd, input logic [2:0] cl, input logic [63:0] tx, input logic [3:0] tl);
    return {7'd0, tl, tx, cl, cd, idx, st};
  endfunction

  // greedy longest prefix, earliest entry wins ties
  function automatic int longest_hit(input bit by_text, input logic [63:0] win, input int wlen);
    int best;
    int best_len;
    int l;
    logic [63:0] s;
    best = -1;
    best_len = 0;
    for (int i = 0; i < entries; i++) begin
      s = by_text ? text_tab[i] : {32'd0, code_tab[i]};
      l = by_text ? int'(tlen_tab[i]) : int'(clen_tab[i]);
      if (l > best_len && l <= wlen && ((s ^ win) & low_bytes(l)) == 64'd0) begin
        best_len = l;
        best = i;
      end
    end
    return best;
  endfunction

  task automatic predict_table(input logic [111:0] d);
    logic [2:0]  cmd;
    int          cl;
    int          tl;
    logic [31:0] cd;
    logic [63:0] tx;
    int          hit;
    cmd = d[2:0];
    cl = (int'(d[37:35]) > tctlm_pkg::MaxCodeBytes) ? tctlm_pkg::MaxCodeBytes : int'(d[37:35]);
    tl = (int'(d[105:102]) > tctlm_pkg::MaxTextBytes) ? tctlm_pkg::MaxTextBytes
                                                       : int'(d[105:102]);
    cd = 32'({32'd0, d[34:3]} & low_bytes(cl));
    tx = d[101:38] & low_bytes(tl);
    case (cmd)
      tctlm_pkg::CMD_CLEAR: begin
        entries = 0;
        term_code = '0;
        term_len = 3'd1;
        want_q.push_back(pack_result(tctlm_pkg::ST_OK, '0, '0, '0, '0, '0));
      end
      tctlm_pkg::CMD_ADD: begin
        if (entries >= tctlm_pkg::MaxEntries) begin
          want_q.push_back(pack_result(tctlm_pkg::ST_FULL, '0, '0, '0, '0, '0));
        end else begin
          code_tab[entries] = cd;
          clen_tab[entries] = 3'(cl);
          text_tab[entries] = tx;
          tlen_tab[entries] = 4'(tl);
          want_q.push_back(pack_result(tctlm_pkg::ST_OK, 8'(entries), cd, 3'(cl), tx, 4'(tl)));
          entries++;
        end
      end
      tctlm_pkg::CMD_SET_TERM: begin
        term_code = cd;
        term_len = 3'(cl);
        want_q.push_back(pack_result(tctlm_pkg::ST_OK, '0, cd, 3'(cl), '0, '0));
      end
      tctlm_pkg::CMD_MATCH_TX, tctlm_pkg::CMD_MATCH_CD: begin
        hit = (cmd == tctlm_pkg::CMD_MATCH_TX) ? longest_hit(1'b1, tx, tl)
                                               : longest_hit(1'b0, {32'd0, cd}, cl);
        if (hit < 0) want_q.push_back(pack_result(tctlm_pkg::ST_NO_HIT, '0, '0, '0, '0, '0));
        else want_q.push_back(pack_result(tctlm_pkg::ST_OK, 8'(hit), code_tab[hit],
                                          clen_tab[hit], text_tab[hit], tlen_tab[hit]));
      end
      tctlm_pkg::CMD_EMIT:
        want_q.push_back(pack_result(tctlm_pkg::ST_OK, '0, term_code, term_len, '0, '0));
      default: want_q.push_back(pack_result(tctlm_pkg::ST_OK, '0, '0, '0, '0, '0));
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    logic [119:0] w;
    if (rst) begin
      fail_count = 0;
      pending_count = 0;
      want_q.delete();
      entries = 0;
      term_code = '0;
      term_len = 3'd1;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (want_q.size() == 0) begin
          $error("unexpected result transfer %h", m_axis_tdata);
          fail_count++;
        end else begin
          w = want_q.pop_front();
          check_field("status", 64'(w[1:0]), 64'(m_axis_tdata[1:0]));
          check_field("entry_index", 64'(w[9:2]), 64'(m_axis_tdata[9:2]));
          check_field("code_out", 64'(w[41:10]), 64'(m_axis_tdata[41:10]));
          check_field("code_len_out", 64'(w[44:42]), 64'(m_axis_tdata[44:42]));
          check_field("text_out", w[108:45], m_axis_tdata[108:45]);
          check_field("text_len_out", 64'(w[112:109]), 64'(m_axis_tdata[112:109]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_table(s_axis_tdata);
      pending_count = want_q.size();
    end
  end
endmodule

FILE: tb/tb_top.sv
// top of the text code table testbench: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_top;
  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // cmd, code_bytes, code_len, text_bytes, text_len, zero fill
  logic [111:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // status, entry_index, code_out, code_len_out, text_out, text_len_out, zero fill
  logic [119:0] m_axis_tdata;
  int           fail_count;
  int           pending_count;
  int           send_idle_pct;
  int           recv_idle_pct;

  // strings handed out by the random part, reused so matches really hit
  logic [31:0]  code_pool [$];
  logic [63:0]  text_pool [$];

  text_code_table_longest_match_unit uut (.*);

  tb_table_checker chk (.*);

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // receiver stalls at its own rate
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= (int'($urandom_range(99)) >= recv_idle_pct);
  end

  // one transfer; valid stays high back to back when no gap is drawn
  task automatic send_item(input logic [2:0] cmd, input logic [31:0] cd, input logic [2:0] cl,
                           input logic [63:0] tx, input logic [3:0] tl);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, tl, tx, cl, cd, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // drop valid and let every expected result arrive
  task automatic drain_all;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (tctlm_pkg::MaxEntries + 10) @(posedge clk);
  endtask

  // strings share a small byte alphabet so prefixes collide often
  function automatic logic [63:0] rand_str;
    logic [63:0] v;
    for (int b = 0; b < 8; b++) v[b*8 +: 8] = ($urandom_range(3) == 0) ? 8'($urandom) :
                                              8'($urandom_range(3) + 8'h41);
    return v;
  endfunction

  task automatic random_item;
    int          pick;
    logic [31:0] cd;
    logic [63:0] tx;
    pick = int'($urandom_range(99));
    cd = 32'(rand_str());
    tx = rand_str();
    if (code_pool.size() > 0 && $urandom_range(1)) cd = code_pool[$urandom_range(code_pool.size()-1)];
    if (text_pool.size() > 0 && $urandom_range(1)) tx = text_pool[$urandom_range(text_pool.size()-1)];
    if (pick < 30) begin
      code_pool.push_back(cd);
      text_pool.push_back(tx);
      send_item(tctlm_pkg::CMD_ADD, cd, 3'($urandom_range(4)), tx, 4'($urandom_range(8)));
    end else if (pick < 60) begin
      send_item(tctlm_pkg::CMD_MATCH_TX, $urandom, 3'($urandom), tx, 4'($urandom_range(8)));
    end else if (pick < 85) begin
      send_item(tctlm_pkg::CMD_MATCH_CD, cd, 3'($urandom_range(4)), {$urandom, $urandom},
                4'($urandom));
    end else if (pick < 90) begin
      send_item(tctlm_pkg::CMD_SET_TERM, $urandom, 3'($urandom), {$urandom, $urandom},
                4'($urandom));
    end else if (pick < 95) begin
      send_item(tctlm_pkg::CMD_EMIT, $urandom, 3'($urandom), {$urandom, $urandom},
                4'($urandom));
    end else if (pick < 97) begin
      send_item(3'($urandom_range(7, 6)), $urandom, 3'($urandom), {$urandom, $urandom},
                4'($urandom));
    end else if (pick < 98) begin
      code_pool.delete();
      text_pool.delete();
      send_item(tctlm_pkg::CMD_CLEAR, $urandom, 3'($urandom), {$urandom, $urandom},
                4'($urandom));
    end else begin
      // noise: raw fields including oversized lengths
      send_item(tctlm_pkg::CMD_MATCH_TX, $urandom, 3'($urandom), {$urandom, $urandom},
                4'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, ties, empty strings, oversized lengths
    send_item(tctlm_pkg::CMD_EMIT, '1, '1, '1, '1);
    send_item(tctlm_pkg::CMD_MATCH_TX, '0, '0, 64'h41, 4'd1);
    send_item(tctlm_pkg::CMD_ADD, 32'h11, 3'd1, 64'h41, 4'd1);
    send_item(tctlm_pkg::CMD_ADD, 32'h22, 3'd1, 64'h41, 4'd1);
    send_item(tctlm_pkg::CMD_ADD, 32'h2211, 3'd2, 64'h4241, 4'd2);
    send_item(tctlm_pkg::CMD_ADD, '1, 3'd7, '1, 4'd15);
    send_item(tctlm_pkg::CMD_ADD, 32'h33, 3'd0, 64'h43, 4'd0);
    send_item(tctlm_pkg::CMD_MATCH_TX, '0, '0, 64'h44434241, 4'd4);
    send_item(tctlm_pkg::CMD_MATCH_TX, '0, '0, 64'h4241, 4'd1);
    send_item(tctlm_pkg::CMD_MATCH_TX, '0, '0, '1, 4'd15);
    send_item(tctlm_pkg::CMD_MATCH_TX, '0, '0, 64'h41, 4'd0);
    send_item(tctlm_pkg::CMD_MATCH_TX, '0, '0, 64'h43, 4'd1);
    send_item(tctlm_pkg::CMD_MATCH_CD, 32'h332211, 3'd3, '0, '0);
    send_item(tctlm_pkg::CMD_MATCH_CD, 32'h22, 3'd1, '0, '0);
    send_item(tctlm_pkg::CMD_MATCH_CD, '1, 3'd7, '0, '0);
    send_item(tctlm_pkg::CMD_SET_TERM, 32'hdeadbeef, 3'd6, '0, '0);
    send_item(tctlm_pkg::CMD_EMIT, '0, '0, '0, '0);
    send_item(tctlm_pkg::CMD_SET_TERM, 32'h5, 3'd0, '0, '0);
    send_item(tctlm_pkg::CMD_EMIT, '0, '0, '0, '0);
    send_item(3'd6, '1, '1, '1, '1);
    send_item(3'd7, '0, '0, '0, '0);
    send_item(tctlm_pkg::CMD_CLEAR, '1, '1, '1, '1);
    send_item(tctlm_pkg::CMD_EMIT, '0, '0, '0, '0);
    send_item(tctlm_pkg::CMD_MATCH_CD, 32'h11, 3'd1, '0, '0);
    // fill the store to the top, then overflow
    for (int i = 0; i < tctlm_pkg::MaxEntries + 2; i++)
      send_item(tctlm_pkg::CMD_ADD, 32'(i), 3'd1, 64'(i), 4'd2);
    send_item(tctlm_pkg::CMD_MATCH_TX, '0, '0, 64'hff, 4'd2);
    send_item(tctlm_pkg::CMD_CLEAR, '0, '0, '0, '0);

    // random in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 46 : 0;
      recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 6 : 0;
      for (int n = 0; n < 430; n++) random_item();
    end
    drain_all();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
